@@ sv/hcbd_pkg.sv @@
// hcbd_pkg: shared codes and the size-digit decoder for the chunked body decoder.
// No dependencies; used by the core.
`default_nettype none

package hcbd_pkg;

  // input item kind
  localparam logic MODE_BEGIN = 1'b0;
  localparam logic MODE_BYTE  = 1'b1;

  // register indexes (byte address = 4 * index)
  localparam logic REG_CHUNKED_MODE = 1'b0;
  localparam logic REG_BODY_LENGTH  = 1'b1;

  localparam int unsigned ADDR_BITS = 3;

  localparam logic [7:0] CHAR_CR = 8'h0D;

  // separator bytes owed
  localparam logic [1:0] SKIP_NONE = 2'd0;
  localparam logic [1:0] SKIP_LF   = 2'd1;  // LF after a size line
  localparam logic [1:0] SKIP_CRLF = 2'd2;  // CR LF after chunk data
  localparam logic [1:0] SKIP_LAST = 2'd3;  // LF CR LF after the zero-size chunk

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] b);
    hex_digit_t d;
    d.ok    = 1'b0;
    d.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      d.ok    = 1'b1;
      d.value = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      d.ok    = 1'b1;
      d.value = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      d.ok    = 1'b1;
      d.value = 4'(b - 8'h37);
    end
    return d;
  endfunction

endpackage

`default_nettype wire

@@ sv/http_chunked_body_decoder_core.sv @@
// http_chunked_body_decoder_core: byte-serial HTTP body decoder (chunked or fixed length).
// Depends on hcbd_pkg. Checker lives in hcbd_checker.sv.
//
// Takes one item per clock while the result register is not stalled and returns one result
// per item, loaded into the result register from the input register.
// An item goes into an input register; the decode step (hex digit, size add, total compare,
// saved-count increment) runs between that register and the result register and updates
// the decoder state in the same cycle. When the result register is stalled the input
// register still takes one more item. Configuration writes go through the APB-style
// port and must be made while no item is in flight.
`default_nettype none

module http_chunked_body_decoder_core #(
  parameter int unsigned LEN_BITS = 32
) (
  input  wire                               clk,
  input  wire                               rst,
  // input items
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire                               mode,
  input  wire  [7:0]                        data_byte,
  input  wire                               end_of_buffer,
  // result items
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic                              payload_valid,
  output logic [7:0]                        payload_byte,
  output logic                              failed,
  output logic                              completed,
  // configuration
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [hcbd_pkg::ADDR_BITS-1:0]    paddr,
  input  wire  [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  // configuration registers
  logic        chunked_mode;
  logic [31:0] body_length;

  // input register
  logic       s1_valid;
  logic       s1_mode;
  logic [7:0] s1_byte;
  logic       s1_eob;

  // decoder state
  logic [LEN_BITS-1:0] size_accumulator, size_accumulator_next;
  logic [LEN_BITS-1:0] expected_total, expected_total_next;
  logic [LEN_BITS-1:0] saved_total, saved_total_next;
  logic [1:0]          bytes_to_skip, bytes_to_skip_next;
  logic                awaiting_last_chunk, awaiting_last_chunk_next;
  logic                error_seen, error_seen_next;
  logic                discarding_buffer, discarding_buffer_next;

  logic                step_payload;
  logic                step_completed;
  logic                s2_load;
  logic                step;
  logic [LEN_BITS-1:0] saved_inc;
  logic [LEN_BITS-1:0] expected_add;
  hcbd_pkg::hex_digit_t digit;

  assign pready  = 1'b1;
  assign s2_load = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s2_load;
  assign step    = s1_valid && s2_load;

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      chunked_mode <= 1'b1;
      body_length  <= 32'd0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        hcbd_pkg::REG_CHUNKED_MODE: chunked_mode <= pwdata[0];
        hcbd_pkg::REG_BODY_LENGTH:  body_length  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      hcbd_pkg::REG_CHUNKED_MODE: prdata = {31'd0, chunked_mode};
      hcbd_pkg::REG_BODY_LENGTH:  prdata = body_length;
      default:                    prdata = 32'd0;
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_mode <= mode;
      s1_byte <= data_byte;
      s1_eob  <= end_of_buffer;
    end
  end

  // decode step
  assign saved_inc    = saved_total + LEN_BITS'(1);
  assign expected_add = expected_total + size_accumulator;
  assign digit        = hcbd_pkg::hex_decode(s1_byte);

  always_comb begin
    size_accumulator_next    = size_accumulator;
    expected_total_next      = expected_total;
    saved_total_next         = saved_total;
    bytes_to_skip_next       = bytes_to_skip;
    awaiting_last_chunk_next = awaiting_last_chunk;
    error_seen_next          = error_seen;
    discarding_buffer_next   = discarding_buffer;
    step_payload             = 1'b0;

    priority if (s1_mode == hcbd_pkg::MODE_BEGIN) begin
      size_accumulator_next    = '0;
      saved_total_next         = '0;
      bytes_to_skip_next       = hcbd_pkg::SKIP_NONE;
      error_seen_next          = 1'b0;
      discarding_buffer_next   = 1'b0;
      awaiting_last_chunk_next = chunked_mode;
      expected_total_next      = chunked_mode ? '0 : LEN_BITS'(body_length);
    end else if (discarding_buffer) begin
      if (s1_eob) begin
        discarding_buffer_next = 1'b0;
      end
    end else if (bytes_to_skip != hcbd_pkg::SKIP_NONE) begin
      bytes_to_skip_next = bytes_to_skip - 2'd1;
    end else if (expected_total > saved_total) begin
      step_payload     = 1'b1;
      saved_total_next = saved_inc;
      if (awaiting_last_chunk && expected_total == saved_inc) begin
        bytes_to_skip_next = hcbd_pkg::SKIP_CRLF;
      end
    end else if (digit.ok) begin
      size_accumulator_next = {size_accumulator[LEN_BITS-5:0], digit.value};
    end else if (s1_byte == hcbd_pkg::CHAR_CR) begin
      expected_total_next   = expected_add;
      size_accumulator_next = '0;
      if (awaiting_last_chunk && size_accumulator == '0) begin
        awaiting_last_chunk_next = 1'b0;
        bytes_to_skip_next       = hcbd_pkg::SKIP_LAST;
      end else begin
        bytes_to_skip_next = hcbd_pkg::SKIP_LF;
      end
    end else begin
      error_seen_next        = 1'b1;
      discarding_buffer_next = !s1_eob;
    end

    step_completed = (expected_total_next == saved_total_next) &&
                     (bytes_to_skip_next == hcbd_pkg::SKIP_NONE) &&
                     !awaiting_last_chunk_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_accumulator    <= '0;
      expected_total      <= '0;
      saved_total         <= '0;
      bytes_to_skip       <= hcbd_pkg::SKIP_NONE;
      awaiting_last_chunk <= 1'b1;
      error_seen          <= 1'b0;
      discarding_buffer   <= 1'b0;
    end else if (step) begin
      size_accumulator    <= size_accumulator_next;
      expected_total      <= expected_total_next;
      saved_total         <= saved_total_next;
      bytes_to_skip       <= bytes_to_skip_next;
      awaiting_last_chunk <= awaiting_last_chunk_next;
      error_seen          <= error_seen_next;
      discarding_buffer   <= discarding_buffer_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      payload_valid <= step_payload;
      payload_byte  <= step_payload ? s1_byte : 8'd0;
      failed        <= error_seen_next;
      completed     <= step_completed;
    end
  end

endmodule

`default_nettype wire

@@ sv/hcbd_checker.sv @@
// hcbd_checker: port-level checks for http_chunked_body_decoder_core, bound into that core.
// Needs only the core's handshake and result ports.
`default_nettype none

module hcbd_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire        payload_valid,
  input wire [7:0]  payload_byte,
  input wire        failed,
  input wire        completed
);

  // the input side only backs up when a result is held and stalled
  a_stall_needs_held_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // non-payload results carry a zero byte
  a_idle_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !payload_valid) |-> (payload_byte == 8'd0))
    else $error("payload byte set on a non-payload item");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(payload_valid) &&
      $stable(payload_byte) && $stable(failed) && $stable(completed)))
    else $error("stalled result changed");

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind http_chunked_body_decoder_core hcbd_checker u_hcbd_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .payload_valid (payload_valid),
  .payload_byte  (payload_byte),
  .failed        (failed),
  .completed     (completed)
);

`default_nettype wire
